// ===== src/cdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared constants, types and index helpers for the circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 5;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 2;
  localparam int CAP_RESET = 16;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic load;
    logic send;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic cnt_t clamp_cap(input logic [CAP_W-1:0] c);
    cnt_t r;
    if (c == '0) begin
      r = cnt_t'(1);
    end else if (int'(c) > DEPTH) begin
      r = cnt_t'(DEPTH);
    end else begin
      r = cnt_t'(c);
    end
    return r;
  endfunction

  function automatic idx_t wrap_next(input idx_t idx, input cnt_t n);
    logic [CNT_W:0] nxt;
    idx_t r;
    nxt = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);
    if (nxt >= (CNT_W + 1)'(n)) begin
      r = '0;
    end else begin
      r = nxt[IDX_W-1:0];
    end
    return r;
  endfunction

  function automatic idx_t wrap_prev(input idx_t idx, input cnt_t n);
    cnt_t m;
    idx_t r;
    m = n - cnt_t'(1);
    if (idx == '0 || (CNT_W + 1)'(idx) >= (CNT_W + 1)'(n)) begin
      r = m[IDX_W-1:0];
    end else begin
      r = idx - idx_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/circular_deque_buffer.sv =====
`timescale 1ns / 1ps
// An item is taken, then passes the execute, load and send states; send waits on a stall.
// The single-item sequencer takes no new item until the last result is sent, and the
//   registered read of the entry store refills the front or rear word.
// Reset: synchronous; capacity returns to 16 and the deque is empty.
// ----------------------------------------------------------------------------
// circular_deque_buffer
// Double-ended queue of 32-bit words in a circular store with set capacity.
// ----------------------------------------------------------------------------
module circular_deque_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,     // capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // push_value
  input  logic [1:0]  s_tuser,      // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,      // popped_value, front_word, rear_word
  output logic [2:0]  m_tuser       // accepted, is_empty, is_full
);

  cdb_pkg::ctrl_cmd_t  cmd;
  cdb_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  cdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cdb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_mode      (s_tuser),
    .in_value     (s_tdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_accepted (m_tuser[0]),
    .out_popped   (m_tdata[31:0]),
    .out_empty    (m_tuser[1]),
    .out_full     (m_tuser[2]),
    .out_front    (m_tdata[63:32]),
    .out_rear     (m_tdata[95:64])
  );

endmodule

// ===== src/cdb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_ctrl
// Sequencer: take an item, execute it, load read data, send the result.
// ----------------------------------------------------------------------------
module cdb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdb_pkg::dp_status_t   status,
  output cdb_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (!status.out_busy) begin
          cmd.send   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/cdb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_datapath
// Entry store, head and tail pointers, end-word caches and result register.
// ----------------------------------------------------------------------------
module cdb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cdb_pkg::ctrl_cmd_t            cmd,
  output cdb_pkg::dp_status_t           status,
  input  logic                          cfg_valid,
  input  logic [cdb_pkg::CAP_W-1:0]     cfg_data,
  input  logic [cdb_pkg::MODE_W-1:0]    in_mode,
  input  cdb_pkg::word_t                in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output cdb_pkg::word_t                out_popped,
  output logic                          out_empty,
  output logic                          out_full,
  output cdb_pkg::word_t                out_front,
  output cdb_pkg::word_t                out_rear
);

  cdb_pkg::word_t mem [cdb_pkg::DEPTH];

  logic [cdb_pkg::CAP_W-1:0]  cap;
  cdb_pkg::idx_t              head;
  cdb_pkg::idx_t              tail;
  logic                       empty;
  logic [cdb_pkg::MODE_W-1:0] mode;
  cdb_pkg::word_t             value;
  cdb_pkg::word_t             front;
  cdb_pkg::word_t             rear;
  cdb_pkg::word_t             popped;
  logic                       accepted;
  cdb_pkg::word_t             rd_data;
  logic                       rd_front;
  logic                       rd_rear;

  cdb_pkg::cnt_t  n;
  logic           full;
  logic           is_push;
  cdb_pkg::idx_t  head_next;
  cdb_pkg::idx_t  tail_next;
  logic           empty_next;
  logic           wr_en;
  cdb_pkg::idx_t  wr_idx;
  cdb_pkg::idx_t  rd_idx;
  logic           rd_front_next;
  logic           rd_rear_next;
  logic           accepted_next;
  cdb_pkg::word_t popped_next;
  cdb_pkg::word_t front_next;
  cdb_pkg::word_t rear_next;

  assign n       = cdb_pkg::clamp_cap(cap);
  assign full    = !empty && (cdb_pkg::wrap_next(tail, n) == head);
  assign is_push = (mode == cdb_pkg::MODE_PUSH_FRONT) || (mode == cdb_pkg::MODE_PUSH_REAR);
  assign status.out_busy = out_valid && !out_ready;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    empty_next    = empty;
    wr_en         = 1'b0;
    wr_idx        = head;
    rd_idx        = head;
    rd_front_next = 1'b0;
    rd_rear_next  = 1'b0;
    accepted_next = 1'b0;
    popped_next   = '1;
    front_next    = front;
    rear_next     = rear;
    if (is_push) begin
      if (!full) begin
        accepted_next = 1'b1;
        wr_en         = 1'b1;
        if (empty) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          wr_idx     = '0;
          front_next = value;
          rear_next  = value;
        end else if (mode == cdb_pkg::MODE_PUSH_FRONT) begin
          head_next  = cdb_pkg::wrap_prev(head, n);
          wr_idx     = head_next;
          front_next = value;
        end else begin
          tail_next  = cdb_pkg::wrap_next(tail, n);
          wr_idx     = tail_next;
          rear_next  = value;
        end
      end
    end else if (!empty) begin
      accepted_next = 1'b1;
      if (head == tail) begin
        popped_next = front;
        head_next   = '0;
        tail_next   = '0;
        empty_next  = 1'b1;
      end else if (mode == cdb_pkg::MODE_POP_FRONT) begin
        popped_next   = front;
        head_next     = cdb_pkg::wrap_next(head, n);
        rd_idx        = head_next;
        rd_front_next = 1'b1;
      end else begin
        popped_next  = rear;
        tail_next    = cdb_pkg::wrap_prev(tail, n);
        rd_idx       = tail_next;
        rd_rear_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= cdb_pkg::CAP_W'(cdb_pkg::CAP_RESET);
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap   <= cfg_data;
        head  <= '0;
        tail  <= '0;
        empty <= 1'b1;
      end else if (cmd.exec) begin
        head  <= head_next;
        tail  <= tail_next;
        empty <= empty_next;
      end
      if (cmd.send) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_idx] <= value;
    end
    if (cmd.exec) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode  <= in_mode;
      value <= in_value;
    end
    if (cmd.exec) begin
      accepted <= accepted_next;
      popped   <= popped_next;
      front    <= front_next;
      rear     <= rear_next;
      rd_front <= rd_front_next;
      rd_rear  <= rd_rear_next;
    end
    if (cmd.load) begin
      if (rd_front) begin
        front <= rd_data;
      end
      if (rd_rear) begin
        rear <= rd_data;
      end
    end
    if (cmd.send) begin
      out_accepted <= accepted;
      out_popped   <= popped;
      out_empty    <= empty;
      out_full     <= full;
      out_front    <= empty ? '1 : front;
      out_rear     <= empty ? '1 : rear;
    end
  end

endmodule

// ===== src/cdb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_checker
// Port-level checks of the circular deque buffer.
// ----------------------------------------------------------------------------
module cdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while another is in flight");

  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
    else $error("deque reported both empty and full");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata[63:32] == '1) && (m_tdata[95:64] == '1))
    else $error("end words not -1 on empty deque");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind circular_deque_buffer cdb_checker u_cdb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== bench/tb_circular_deque_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque_buffer
// Self-checking bench for the circular deque buffer. Push and pop items
// stream through the block under several capacity settings and idle
// patterns, with one long output stall. Every result is checked against a
// deque kept by the bench.
// ----------------------------------------------------------------------------
module tb_circular_deque_buffer;
  import cdb_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    word_t             value;
  } deque_op_t;

  typedef struct packed {
    logic  accepted;
    word_t popped;
    logic  is_empty;
    logic  is_full;
    word_t front;
    word_t rear;
  } deque_view_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [95:0] m_tdata;
  logic [2:0]  m_tuser;

  deque_op_t   pending_ops[$];
  deque_view_t view_queue[$];
  logic        in_fire     = 1'b0;
  logic        hold_rx     = 1'b0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          fail_count  = 0;
  int          cycle_count = 0;

  word_t       shadow_store[DEPTH];
  int          head_ptr;
  int          tail_ptr;
  bit          shadow_empty;
  logic [4:0]  cap_reg;

  circular_deque_buffer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int cap_in_use();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic int step_fwd(input int i);
    return (i + 1 >= cap_in_use()) ? 0 : i + 1;
  endfunction

  function automatic int step_back(input int i);
    return (i == 0 || i >= cap_in_use()) ? cap_in_use() - 1 : i - 1;
  endfunction

  function automatic bit shadow_full();
    return !shadow_empty && step_fwd(tail_ptr) == head_ptr;
  endfunction

  function automatic deque_view_t deque_step(input deque_op_t op);
    deque_view_t r;
    r.accepted = 1'b0;
    r.popped   = '1;
    if (op.mode == MODE_PUSH_FRONT || op.mode == MODE_PUSH_REAR) begin
      if (!shadow_full()) begin
        r.accepted = 1'b1;
        if (shadow_empty) begin
          head_ptr        = 0;
          tail_ptr        = 0;
          shadow_empty    = 1'b0;
          shadow_store[0] = op.value;
        end else if (op.mode == MODE_PUSH_FRONT) begin
          head_ptr               = step_back(head_ptr);
          shadow_store[head_ptr] = op.value;
        end else begin
          tail_ptr               = step_fwd(tail_ptr);
          shadow_store[tail_ptr] = op.value;
        end
      end
    end else if (!shadow_empty) begin
      r.accepted = 1'b1;
      if (head_ptr == tail_ptr) begin
        r.popped     = shadow_store[head_ptr];
        head_ptr     = 0;
        tail_ptr     = 0;
        shadow_empty = 1'b1;
      end else if (op.mode == MODE_POP_FRONT) begin
        r.popped = shadow_store[head_ptr];
        head_ptr = step_fwd(head_ptr);
      end else begin
        r.popped = shadow_store[tail_ptr];
        tail_ptr = step_back(tail_ptr);
      end
    end
    r.is_empty = shadow_empty;
    r.is_full  = shadow_full();
    r.front    = shadow_empty ? '1 : shadow_store[head_ptr];
    r.rear     = shadow_empty ? '1 : shadow_store[tail_ptr];
    return r;
  endfunction

  task automatic report_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : monitor
    deque_op_t   op;
    deque_view_t want;
    deque_view_t got;
    if (rst) begin
      in_fire      <= 1'b0;
      head_ptr     = 0;
      tail_ptr     = 0;
      shadow_empty = 1'b1;
      cap_reg      = 5'(CAP_RESET);
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        cap_reg      = cfg_data;
        head_ptr     = 0;
        tail_ptr     = 0;
        shadow_empty = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        op.mode  = s_tuser;
        op.value = s_tdata;
        view_queue.push_back(deque_step(op));
      end
      if (m_tvalid && m_tready) begin
        got.accepted = m_tuser[0];
        got.is_empty = m_tuser[1];
        got.is_full  = m_tuser[2];
        got.popped   = m_tdata[31:0];
        got.front    = m_tdata[63:32];
        got.rear     = m_tdata[95:64];
        if (view_queue.size() == 0) begin
          report_fault($sformatf("unexpected result at cycle %0d", cycle_count));
        end else begin
          want = view_queue.pop_front();
          if (want !== got) begin
            report_fault($sformatf(
              "mismatch cycle %0d: exp acc=%0b pop=%h emp=%0b full=%0b front=%h rear=%h",
              cycle_count, want.accepted, want.popped, want.is_empty, want.is_full,
              want.front, want.rear));
            if (fail_count <= 10) begin
              $display("  got acc=%0b pop=%h emp=%0b full=%0b front=%h rear=%h",
                       got.accepted, got.popped, got.is_empty, got.is_full,
                       got.front, got.rear);
            end
          end
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    deque_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= op.mode;
        s_tdata  <= op.value;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_circular_deque_buffer failed");
      $finish;
    end
  end

  task automatic add_op(input logic [MODE_W-1:0] mode, input word_t value);
    deque_op_t op;
    op.mode  = mode;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || s_tvalid || view_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    int    left;
    int    burst;
    int    push_bias;
    word_t value;
    left = count;
    while (left > 0) begin
      burst     = $urandom_range(2 * cap_in_use() + 2, 1);
      push_bias = $urandom_range(1) ? 75 : 25;
      for (int k = 0; k < burst && left > 0; k++) begin
        case ($urandom_range(9))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7fff_ffff;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom;
        endcase
        if ($urandom_range(99) < push_bias) begin
          add_op($urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT, value);
        end else begin
          add_op($urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT, value);
        end
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [4:0] cap_value, input bit write_cap, input int idle,
                           input int stall, input int count, input bit hold);
    wait_idle();
    if (write_cap) write_capacity(cap_value);
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    queue_random(count);
    if (hold) begin
      fork
        begin
          @(posedge clk);
          hold_rx = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_rx = 1'b0;
        end
      join_none
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_op(MODE_POP_FRONT, 32'h1234_5678);
    add_op(MODE_POP_REAR, 32'h0);
    add_op(MODE_PUSH_FRONT, 32'h8000_0000);
    add_op(MODE_PUSH_REAR, 32'h7fff_ffff);
    add_op(MODE_PUSH_FRONT, 32'h0);
    add_op(MODE_PUSH_REAR, 32'hffff_ffff);
    add_op(MODE_POP_FRONT, 32'h0);
    add_op(MODE_POP_REAR, 32'h0);
    add_op(MODE_POP_FRONT, 32'h0);
    add_op(MODE_POP_REAR, 32'h0);
    add_op(MODE_POP_FRONT, 32'h0);
    add_op(MODE_PUSH_REAR, 32'h5555_aaaa);
    add_op(MODE_PUSH_FRONT, 32'haaaa_5555);
    add_op(MODE_POP_REAR, 32'h0);
    add_op(MODE_POP_REAR, 32'h0);

    run_phase(5'd16, 1'b0, 0, 0, 150, 1'b1);
    run_phase(5'd1, 1'b1, 69, 0, 120, 1'b0);
    run_phase(5'd2, 1'b1, 0, 69, 150, 1'b0);
    run_phase(5'd0, 1'b1, 7, 7, 100, 1'b0);
    run_phase(5'd31, 1'b1, 0, 0, 200, 1'b0);
    run_phase(5'd17, 1'b1, 7, 7, 100, 1'b0);
    run_phase(5'd5, 1'b1, 69, 0, 150, 1'b0);
    run_phase(5'd16, 1'b1, 0, 69, 130, 1'b0);
    wait_idle();

    if (fail_count == 0 && view_queue.size() == 0) begin
      $display("tb_circular_deque_buffer passed");
    end else begin
      $display("tb_circular_deque_buffer failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cdb_pkg.sv
src/cdb_ctrl.sv
src/cdb_datapath.sv
src/circular_deque_buffer.sv
src/cdb_checker.sv
bench/tb_circular_deque_buffer.sv
